// ----- hw/rtl/cpu8afb_pkg.sv -----
// ----------------------------------------------------------------------------
// cpu8afb_pkg
// Shared types and codes of the 8-bit ALU, flag and branch unit: command
// codes, register and flag selectors, and the command and result words.
// ----------------------------------------------------------------------------
package cpu8afb_pkg;

    // Command codes
    typedef enum logic [4:0] {
        CMD_LOAD     = 5'd0,
        CMD_TRANSFER = 5'd1,
        CMD_INC_REG  = 5'd2,
        CMD_DEC_REG  = 5'd3,
        CMD_INC_MEM  = 5'd4,
        CMD_DEC_MEM  = 5'd5,
        CMD_ADC      = 5'd6,
        CMD_SBC      = 5'd7,
        CMD_AND      = 5'd8,
        CMD_ORA      = 5'd9,
        CMD_EOR      = 5'd10,
        CMD_BIT      = 5'd11,
        CMD_CMP      = 5'd12,
        CMD_ASL      = 5'd13,
        CMD_LSR      = 5'd14,
        CMD_ROL      = 5'd15,
        CMD_ROR      = 5'd16,
        CMD_BRANCH   = 5'd17,
        CMD_PACK     = 5'd18,
        CMD_UNPACK   = 5'd19,
        CMD_IRQ      = 5'd20,
        CMD_NMI      = 5'd21
    } t_command;

    // Register selectors
    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_X = 2'd1;
    localparam logic [1:0] SEL_Y = 2'd2;

    // Branch flag selectors
    localparam logic [1:0] FLAG_N = 2'd0;
    localparam logic [1:0] FLAG_V = 2'd1;
    localparam logic [1:0] FLAG_C = 2'd2;
    localparam logic [1:0] FLAG_Z = 2'd3;

    // Extra branch cycles
    localparam logic [1:0] EXTRA_NONE  = 2'd0;
    localparam logic [1:0] EXTRA_TAKEN = 2'd1;
    localparam logic [1:0] EXTRA_PAGE  = 2'd2;

    // Command word
    typedef struct packed {
        logic [4:0]  command;
        logic [1:0]  register_select;
        logic [1:0]  destination_select;
        logic [7:0]  operand_value;
        logic        shift_on_memory;
        logic [1:0]  flag_select;
        logic        branch_condition;
        logic [15:0] program_counter;
        logic        break_bit;
    } t_cmd;

    // Result word
    typedef struct packed {
        logic [7:0]  result_value;
        logic [7:0]  status_byte;
        logic [7:0]  acc_out;
        logic [7:0]  x_out;
        logic [7:0]  y_out;
        logic [15:0] next_pc;
        logic [1:0]  extra_cycles;
        logic        interrupt_taken;
    } t_res;

endpackage

// ----- hw/rtl/cpu8afb_cmd_if.sv -----
// ----------------------------------------------------------------------------
// cpu8afb_cmd_if
// Valid/ready channel that carries one command word.
// ----------------------------------------------------------------------------
interface cpu8afb_cmd_if
    import cpu8afb_pkg::*;
;
    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/cpu8afb_res_if.sv -----
// ----------------------------------------------------------------------------
// cpu8afb_res_if
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface cpu8afb_res_if
    import cpu8afb_pkg::*;
;
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/cpu8_alu_flag_branch_unit.sv -----
// ----------------------------------------------------------------------------
// cpu8_alu_flag_branch_unit
// Execution unit of an 8-bit accumulator processor: A, X, Y and the
// N V D I Z C flags, binary ADC/SBC, logic, shifts, compare, relative
// branch target, status pack/unpack and interrupt entry.
// ----------------------------------------------------------------------------
//  port     | dir | word  | contents
//  ---------+-----+-------+-------------------------------------------------
//  i_cmd    | in  | t_cmd | command, selectors, operand, pc, break bit
//  o_res    | out | t_res | write-back byte, status, A/X/Y, next pc, extras
//
//  A command is registered in the input stage, then in the result stage;
//  one word per cycle while o_res is taken. The ALU and flag logic
//  runs into the result register, and A/X/Y/flags update as it moves.
//  A stalled result holds both stages; i_cmd.ready drops only when both
//  stages are full and o_res is not taken.
//  Synchronous active-low reset empties both stages, clears A/X/Y and the
//  flags, and sets I.
// ----------------------------------------------------------------------------
module cpu8_alu_flag_branch_unit
    import cpu8afb_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    cpu8afb_cmd_if.sink    i_cmd,
    cpu8afb_res_if.source  o_res
);

    logic       r_in_valid;
    t_cmd       r_in;
    logic       r_out_valid;
    t_res       r_out;

    logic [7:0] r_acc, r_x, r_y;
    logic       r_flag_c, r_flag_z, r_flag_i, r_flag_d, r_flag_v, r_flag_n;

    logic [7:0] n_acc, n_x, n_y;
    logic       n_flag_c, n_flag_z, n_flag_i, n_flag_d, n_flag_v, n_flag_n;
    t_res       n_out;

    logic       advance;
    logic [7:0] src_reg;
    logic [7:0] shift_src;
    logic [7:0] val;
    logic [8:0] wide;
    logic       flag_pick;
    logic [15:0] pc_base;
    logic [15:0] pc_target;
    logic [7:0] pack_brk;

    // Move the input stage into the result stage when it is free or drained
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Read the selected source register; selector three reads as zero
    always_comb begin
        case (r_in.register_select)
            SEL_A:   src_reg = r_acc;
            SEL_X:   src_reg = r_x;
            SEL_Y:   src_reg = r_y;
            default: src_reg = 8'h00;
        endcase
    end

    assign shift_src = r_in.shift_on_memory ? r_in.operand_value : r_acc;
    assign pack_brk  = {r_flag_n, r_flag_v, 1'b1, r_in.break_bit,
                        r_flag_d, r_flag_i, r_flag_z, r_flag_c};
    assign pc_base   = r_in.program_counter + 16'd2;
    assign pc_target = pc_base + {{8{r_in.operand_value[7]}}, r_in.operand_value};

    // Pick the tested branch flag
    always_comb begin
        case (r_in.flag_select)
            FLAG_N:  flag_pick = r_flag_n;
            FLAG_V:  flag_pick = r_flag_v;
            FLAG_C:  flag_pick = r_flag_c;
            default: flag_pick = r_flag_z;
        endcase
    end

    // Execute one command against the current state
    always_comb begin
        n_acc    = r_acc;
        n_x      = r_x;
        n_y      = r_y;
        n_flag_c = r_flag_c;
        n_flag_z = r_flag_z;
        n_flag_i = r_flag_i;
        n_flag_d = r_flag_d;
        n_flag_v = r_flag_v;
        n_flag_n = r_flag_n;
        val      = 8'h00;
        wide     = 9'h000;
        n_out    = '0;

        case (r_in.command)
            CMD_LOAD, CMD_TRANSFER: begin
                val = (r_in.command == CMD_LOAD) ? r_in.operand_value : src_reg;
                case (r_in.destination_select)
                    SEL_A:   n_acc = val;
                    SEL_X:   n_x   = val;
                    SEL_Y:   n_y   = val;
                    default: ;
                endcase
                n_flag_z = (val == 8'h00);
                n_flag_n = val[7];
            end
            CMD_INC_REG, CMD_DEC_REG: begin
                val = (r_in.command == CMD_INC_REG) ? src_reg + 8'd1 : src_reg - 8'd1;
                case (r_in.register_select)
                    SEL_A:   n_acc = val;
                    SEL_X:   n_x   = val;
                    SEL_Y:   n_y   = val;
                    default: ;
                endcase
                n_flag_z = (val == 8'h00);
                n_flag_n = val[7];
            end
            CMD_INC_MEM, CMD_DEC_MEM: begin
                val = (r_in.command == CMD_INC_MEM) ? r_in.operand_value + 8'd1
                                                    : r_in.operand_value - 8'd1;
                n_out.result_value = val;
                n_flag_z = (val == 8'h00);
                n_flag_n = val[7];
            end
            CMD_ADC: begin
                wide = {1'b0, r_acc} + {1'b0, r_in.operand_value} + {8'h00, r_flag_c};
                val  = wide[7:0];
                n_flag_c = wide[8];
                n_flag_v = (r_acc[7] ^ val[7]) & (r_in.operand_value[7] ^ val[7]);
                n_acc    = val;
                n_flag_z = (val == 8'h00);
                n_flag_n = val[7];
            end
            CMD_SBC: begin
                wide = {1'b0, r_acc} - {1'b0, r_in.operand_value} - {8'h00, !r_flag_c};
                val  = wide[7:0];
                n_flag_c = !wide[8];
                n_flag_v = (r_acc[7] ^ r_in.operand_value[7]) & (r_acc[7] ^ val[7]);
                n_acc    = val;
                n_flag_z = (val == 8'h00);
                n_flag_n = val[7];
            end
            CMD_AND, CMD_ORA, CMD_EOR: begin
                case (r_in.command)
                    CMD_AND: val = r_acc & r_in.operand_value;
                    CMD_ORA: val = r_acc | r_in.operand_value;
                    default: val = r_acc ^ r_in.operand_value;
                endcase
                n_acc    = val;
                n_flag_z = (val == 8'h00);
                n_flag_n = val[7];
            end
            CMD_BIT: begin
                n_flag_z = ((r_in.operand_value & r_acc) == 8'h00);
                n_flag_v = r_in.operand_value[6];
                n_flag_n = r_in.operand_value[7];
            end
            CMD_CMP: begin
                wide = {1'b0, src_reg} - {1'b0, r_in.operand_value};
                n_flag_z = (src_reg == r_in.operand_value);
                n_flag_c = !wide[8];
                n_flag_n = wide[7];
            end
            CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
                case (r_in.command)
                    CMD_ASL: begin
                        n_flag_c = shift_src[7];
                        val      = {shift_src[6:0], 1'b0};
                    end
                    CMD_LSR: begin
                        n_flag_c = shift_src[0];
                        val      = {1'b0, shift_src[7:1]};
                    end
                    CMD_ROL: begin
                        n_flag_c = shift_src[7];
                        val      = {shift_src[6:0], r_flag_c};
                    end
                    default: begin
                        n_flag_c = shift_src[0];
                        val      = {r_flag_c, shift_src[7:1]};
                    end
                endcase
                n_flag_z = (val == 8'h00);
                n_flag_n = val[7];
                if (r_in.shift_on_memory) begin
                    n_out.result_value = val;
                end else begin
                    n_acc = val;
                end
            end
            CMD_BRANCH: begin
                n_out.next_pc = pc_base;
                if (flag_pick == r_in.branch_condition) begin
                    n_out.next_pc      = pc_target;
                    n_out.extra_cycles = (pc_base[15:8] != pc_target[15:8]) ? EXTRA_PAGE
                                                                            : EXTRA_TAKEN;
                end
            end
            CMD_PACK: begin
                n_out.result_value = pack_brk;
            end
            CMD_UNPACK: begin
                n_flag_c = r_in.operand_value[0];
                n_flag_z = r_in.operand_value[1];
                n_flag_i = r_in.operand_value[2];
                n_flag_d = r_in.operand_value[3];
                n_flag_v = r_in.operand_value[6];
                n_flag_n = r_in.operand_value[7];
            end
            CMD_IRQ, CMD_NMI: begin
                if (r_in.command == CMD_NMI || !r_flag_i) begin
                    n_out.result_value    = pack_brk;
                    n_out.interrupt_taken = 1'b1;
                    n_flag_d = 1'b0;
                    n_flag_i = 1'b1;
                end
            end
            default: ;
        endcase

        n_out.status_byte = {n_flag_n, n_flag_v, 1'b1, 1'b0,
                             n_flag_d, n_flag_i, n_flag_z, n_flag_c};
        n_out.acc_out     = n_acc;
        n_out.x_out       = n_x;
        n_out.y_out       = n_y;
    end

    // Control: stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: capture command and result words
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in <= i_cmd.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Architectural registers and flags: update as a command retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= 8'h00;
            r_x      <= 8'h00;
            r_y      <= 8'h00;
            r_flag_c <= 1'b0;
            r_flag_z <= 1'b0;
            r_flag_i <= 1'b1;
            r_flag_d <= 1'b0;
            r_flag_v <= 1'b0;
            r_flag_n <= 1'b0;
        end else if (advance) begin
            r_acc    <= n_acc;
            r_x      <= n_x;
            r_y      <= n_y;
            r_flag_c <= n_flag_c;
            r_flag_z <= n_flag_z;
            r_flag_i <= n_flag_i;
            r_flag_d <= n_flag_d;
            r_flag_v <= n_flag_v;
            r_flag_n <= n_flag_n;
        end
    end

    // An NMI always leaves I set and D clear
    a_nmi_masks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in.command == CMD_NMI) |=> r_flag_i && !r_flag_d)
        else $error("NMI entry did not set I and clear D");

    // A taken interrupt reports I set and D clear in its status word
    a_int_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.interrupt_taken |-> r_out.status_byte[2] && !r_out.status_byte[3])
        else $error("interrupt result carries wrong I/D flags");

    // Only a branch produces a next pc or extra cycles
    a_branch_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in.command != CMD_BRANCH)
            |=> (r_out.next_pc == 16'h0000) && (r_out.extra_cycles == EXTRA_NONE))
        else $error("non-branch result carries branch fields");

    // Result status copies the live flags once the word is written
    a_status_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out.status_byte == {r_flag_n, r_flag_v, 1'b1, 1'b0,
                                          r_flag_d, r_flag_i, r_flag_z, r_flag_c})
        else $error("result status differs from flag registers");

endmodule
